[hw/rtl/rc_channel_mixer_unit_defines.svh]
// Assertion macros used by the channel mixer sequencer (rcm_ctrl).
// No dependencies; expects signals named clock and reset in the using scope.
`ifndef RC_CHANNEL_MIXER_UNIT_DEFINES_SVH
`define RC_CHANNEL_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RCM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RCM_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define RCM_ASSERT(lbl, prop, msg)
`define RCM_NEVER(lbl, cond, msg)
`endif

`endif

[hw/rtl/rcm_pkg.sv]
// Shared constants, types and helper functions of the channel mixer.
// No dependencies; imported by every module of the block but rcm_ram.
package rcm_pkg;

   localparam int NUM_CHANNELS       = 16;
   localparam int NUM_MIXERS         = 6;
   localparam int NUM_SOURCES        = 200;
   localparam int SOURCES_PER_DEVICE = 50;
   localparam int NUM_DEVICES        =
      (NUM_SOURCES + SOURCES_PER_DEVICE - 1) / SOURCES_PER_DEVICE;

   localparam int ID_W      = 8;
   localparam int ADDR_W    = $clog2(NUM_SOURCES);
   localparam int VAL_W     = 16;
   localparam int SIDE_W    = 18;
   localparam int SUM_W     = 19;
   localparam int CHAN_W    = 4;
   localparam int OP_W      = 2;
   localparam int DEV_W     = 2;
   localparam int ENTRY_W   = 25;
   localparam int PAIR_W    = 50;
   localparam int NUM_PAIRS = 3;
   localparam int MAP_W     = 64;
   localparam int INV_W     = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [ID_W-1:0] SKIP_ID   = 8'd22;
   localparam logic [ID_W-1:0] BUTTON_LO = 8'd8;
   localparam logic [ID_W-1:0] BUTTON_HI = 8'd39;
   localparam logic signed [SIDE_W-1:0] RAIL_HI = 18'sd32767;
   localparam logic signed [SIDE_W-1:0] RAIL_LO = -18'sd32767;

   localparam logic [PAIR_W-1:0] PAIR_RESET = 50'd536870928;

   // transaction opcodes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_FRAME = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT   = 3'd6;

   typedef struct packed {
      logic              store_write;
      logic              clear_dev;
      logic              issue_a;
      logic              issue_b;
      logic              load_out;
      logic [CHAN_W-1:0] chan;
      logic              last;
   } cmd_type;

   typedef struct packed {
      logic enabled;
   } status_type;

   // id mod SOURCES_PER_DEVICE falls in the button range (ids from NUM_SOURCES up are never buttons)
   function automatic logic is_toggle_id(input logic [ID_W-1:0] id);
      logic [ID_W-1:0] loc;
      loc = '0;
      for (int k = 0; k < NUM_DEVICES; k++) begin
         if (int'(id) >= k * SOURCES_PER_DEVICE &&
             int'(id) < (k + 1) * SOURCES_PER_DEVICE) begin
            loc = ID_W'(int'(id) - k * SOURCES_PER_DEVICE);
         end
      end
      return (loc >= BUTTON_LO) && (loc <= BUTTON_HI);
   endfunction

   function automatic logic signed [SIDE_W-1:0] side_value(
      input logic signed [VAL_W-1:0] raw,
      input logic                    zero,
      input logic                    button,
      input logic                    center,
      input logic                    reverse);
      logic signed [SIDE_W-1:0] v;
      logic signed [SIDE_W-1:0] r;
      r = SIDE_W'(raw);
      if (zero) begin
         v = '0;
      end else if (button) begin
         if (raw == '0) begin
            v = center ? '0 : RAIL_LO;
         end else begin
            v = RAIL_HI;
         end
      end else begin
         v = center ? ((r <<< 1) - RAIL_HI) : r;
      end
      if (zero) begin
         return '0;
      end
      return reverse ? -v : v;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(32767)) begin
         return 16'sh7FFF;
      end
      if (v < -SUM_W'(32768)) begin
         return 16'sh8000;
      end
      return v[VAL_W-1:0];
   endfunction

endpackage

[hw/rtl/rcm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 200
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rcm_ctrl.sv]
// Sequencer of the channel mixer: request handshake, channel counter, result valid.
// Depends on rcm_pkg and rc_channel_mixer_unit_defines.svh.
`include "rc_channel_mixer_unit_defines.svh"

module rcm_ctrl import rcm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  status_type      status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {S_IDLE, S_ISSUE_A, S_ISSUE_B, S_CALC} state_type;

   state_type         state_ff, state_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              last_ch;
   logic              out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_ch   = (ch_ff == CHAN_W'(NUM_CHANNELS - 1));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in          = state_ff;
      ch_in             = ch_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      cmd.store_write   = 1'b0;
      cmd.clear_dev     = 1'b0;
      cmd.issue_a       = 1'b0;
      cmd.issue_b       = 1'b0;
      cmd.load_out      = 1'b0;
      cmd.chan          = ch_ff;
      cmd.last          = last_ch;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_WRITE: cmd.store_write = 1'b1;
                  OP_CLEAR: cmd.clear_dev = 1'b1;
                  OP_FRAME: begin
                     if (status.enabled) begin
                        ch_in    = '0;
                        state_in = S_ISSUE_A;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ISSUE_A: begin
            cmd.issue_a = 1'b1;
            state_in    = S_ISSUE_B;
         end
         S_ISSUE_B: begin
            cmd.issue_b = 1'b1;
            state_in    = S_CALC;
         end
         S_CALC: begin
            // hold here while the previous result is still unclaimed
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (last_ch) begin
                  state_in = S_IDLE;
               end else begin
                  ch_in    = ch_ff + CHAN_W'(1);
                  state_in = S_ISSUE_A;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `RCM_NEVER(a_no_overwrite, cmd.load_out && rsp_valid_ff && !rsp_ready, "result overwritten")
   `RCM_ASSERT(a_frame_start, (accept && req_op == OP_FRAME && status.enabled) |=> (state_ff == S_ISSUE_A && ch_ff == '0), "frame did not start at channel zero")
   `RCM_ASSERT(a_last_ends, (cmd.load_out && cmd.last) |=> (state_ff == S_IDLE), "frame did not end after last channel")
   `RCM_NEVER(a_store_busy, (cmd.store_write || cmd.clear_dev) && state_ff != S_IDLE, "store update during frame")

endmodule

[hw/rtl/rcm_datapath.sv]
// Datapath of the channel mixer: config registers, source store, mixer arithmetic.
// Depends on rcm_pkg and rcm_ram.
module rcm_datapath import rcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [ID_W-1:0]          req_source_index,
   input  logic signed [VAL_W-1:0]  req_source_value,
   input  logic [DEV_W-1:0]         req_device,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wr_data,
   output logic [CHAN_W-1:0]        rsp_channel,
   output logic signed [VAL_W-1:0]  rsp_mixed_value,
   output logic signed [VAL_W-1:0]  rsp_output_value,
   output logic                     rsp_last
);

   // configuration
   logic                 enabled_ff;
   logic [PAIR_W-1:0]    pair_ff [NUM_PAIRS];
   logic [MAP_W-1:0]     map_low_ff, map_high_ff;
   logic [INV_W-1:0]     invert_ff;

   // store valid bits: an entry never written since reset or clear reads as zero
   logic [NUM_SOURCES-1:0] valid_ff, valid_in;

   // per-channel working registers
   logic                    found_ff;
   logic [ID_W-1:0]         neg_id_ff;
   logic                    a_c_ff, a_r_ff, neg_c_ff, neg_r_ff;
   // rd_zero: id is skip or past the store; rd_live: entry holds a written value
   logic                    rd_zero_ff, rd_live_ff, rd_button_ff;
   logic signed [SIDE_W-1:0] side_a_ff;

   // result registers
   logic [CHAN_W-1:0]       chan_out_ff;
   logic signed [VAL_W-1:0] mixed_out_ff, final_out_ff;
   logic                    last_out_ff;

   // mixer lookup
   logic [ENTRY_W-1:0] entry [NUM_MIXERS];
   logic [ENTRY_W-1:0] sel_entry;
   logic               sel_found;
   logic [2*MAP_W-1:0] map_all;
   logic [ID_W-1:0]    map_id;
   logic [ID_W-1:0]    first_id;

   // read port
   logic [ID_W-1:0]         rd_id;
   logic                    rd_ok;
   logic [ADDR_W-1:0]       rd_addr;
   logic                    rd_valid;
   logic                    rd_en;
   logic [VAL_W-1:0]        ram_q;
   logic signed [VAL_W-1:0] raw_q;
   logic                    wr_en;

   // arithmetic
   logic signed [SIDE_W-1:0] side_a_val, side_b_val;
   logic signed [SUM_W-1:0]  sum;
   logic signed [VAL_W-1:0]  mixed, final_val;

   always_comb begin
      for (int m = 0; m < NUM_MIXERS; m++) begin
         entry[m] = pair_ff[m / 2][(m % 2) * ENTRY_W +: ENTRY_W];
      end
      sel_found = 1'b0;
      sel_entry = '0;
      // scan downward so the lowest matching mixer wins
      for (int m = NUM_MIXERS - 1; m >= 0; m--) begin
         if (entry[m][4:0] == {1'b0, cmd.chan}) begin
            sel_found = 1'b1;
            sel_entry = entry[m];
         end
      end
   end

   assign map_all  = {map_high_ff, map_low_ff};
   assign map_id   = map_all[cmd.chan * ID_W +: ID_W];
   assign first_id = sel_found ? sel_entry[12:5] : map_id;

   assign rd_id    = cmd.issue_a ? first_id : neg_id_ff;
   assign rd_ok    = (rd_id < ID_W'(NUM_SOURCES)) && (rd_id != SKIP_ID);
   assign rd_addr  = rd_id[ADDR_W-1:0];
   assign rd_valid = rd_ok ? valid_ff[rd_addr] : 1'b0;
   assign rd_en    = (cmd.issue_a || cmd.issue_b) && rd_ok;
   assign wr_en    = cmd.store_write && (req_source_index < ID_W'(NUM_SOURCES));

   rcm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (NUM_SOURCES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_source_index[ADDR_W-1:0]),
      .wr_data (req_source_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // an unwritten entry is a stored zero, still subject to button/axis rules
   assign raw_q = rd_live_ff ? $signed(ram_q) : '0;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[req_source_index[ADDR_W-1:0]] = 1'b1;
      end
      if (cmd.clear_dev) begin
         for (int i = 0; i < NUM_SOURCES; i++) begin
            if (i >= int'(req_device) * SOURCES_PER_DEVICE &&
                i < (int'(req_device) + 1) * SOURCES_PER_DEVICE) begin
               valid_in[i] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      if (found_ff) begin
         side_a_val = side_value(raw_q, rd_zero_ff, rd_button_ff, a_c_ff, a_r_ff);
         side_b_val = side_value(raw_q, rd_zero_ff, rd_button_ff, neg_c_ff, neg_r_ff);
      end else begin
         side_a_val = rd_zero_ff ? '0 : SIDE_W'(raw_q);
         side_b_val = '0;
      end
      sum       = SUM_W'(side_a_ff) + SUM_W'(side_b_val);
      mixed     = sat16(sum);
      final_val = invert_ff[cmd.chan] ? sat16(-SUM_W'(mixed)) : mixed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff  <= 1'b0;
         for (int p = 0; p < NUM_PAIRS; p++) begin
            pair_ff[p] <= PAIR_RESET;
         end
         map_low_ff  <= '1;
         map_high_ff <= '1;
         invert_ff   <= '0;
         valid_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ENABLED:  enabled_ff  <= csr_wr_data[0];
               CSR_PAIR_0:   pair_ff[0]  <= csr_wr_data[PAIR_W-1:0];
               CSR_PAIR_1:   pair_ff[1]  <= csr_wr_data[PAIR_W-1:0];
               CSR_PAIR_2:   pair_ff[2]  <= csr_wr_data[PAIR_W-1:0];
               CSR_MAP_LOW:  map_low_ff  <= csr_wr_data;
               CSR_MAP_HIGH: map_high_ff <= csr_wr_data;
               CSR_INVERT:   invert_ff   <= csr_wr_data[INV_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_a) begin
         found_ff  <= sel_found;
         neg_id_ff <= sel_entry[20:13];
         a_c_ff    <= sel_found && sel_entry[21];
         a_r_ff    <= sel_found && sel_entry[22];
         neg_c_ff  <= sel_entry[23];
         neg_r_ff  <= sel_entry[24];
      end
      if (cmd.issue_a || cmd.issue_b) begin
         rd_zero_ff   <= !rd_ok;
         rd_live_ff   <= rd_valid;
         rd_button_ff <= is_toggle_id(rd_id);
      end
      if (cmd.issue_b) begin
         side_a_ff <= side_a_val;
      end
      if (cmd.load_out) begin
         chan_out_ff  <= cmd.chan;
         mixed_out_ff <= mixed;
         final_out_ff <= final_val;
         last_out_ff  <= cmd.last;
      end
   end

   assign status.enabled   = enabled_ff;
   assign rsp_channel      = chan_out_ff;
   assign rsp_mixed_value  = mixed_out_ff;
   assign rsp_output_value = final_out_ff;
   assign rsp_last         = last_out_ff;

endmodule

[hw/rtl/rc_channel_mixer_unit.sv]
// Top level of the RC channel mixer: source store plus per-frame channel mixing.
// Depends on rcm_pkg, rcm_ctrl, rcm_datapath (and rcm_ram below it).
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  op, source_index, source_value, device
//  rsp      out        rsp_valid/rsp_ready  channel, mixed_value, output_value, last
//  csr      in         csr_wr_en            csr_index, csr_wr_data (write only)
//
// Write and clear transactions complete on acceptance; req_ready stays high.
// An enabled frame keeps req_ready low through all 16 channels: three steps each
// (two reads on the single store read port, then the sum), one result per sum step.
// A result still unclaimed at the next channel's sum step holds the sequencer there;
// shorter rsp stalls cost nothing.
// Reset (synchronous) clears every store entry at once through per-entry valid bits.
module rc_channel_mixer_unit import rcm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request transactions
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OP_W-1:0]          req_op,
   input  logic [ID_W-1:0]          req_source_index,
   input  logic signed [VAL_W-1:0]  req_source_value,
   input  logic [DEV_W-1:0]         req_device,
   // result transactions
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CHAN_W-1:0]        rsp_channel,
   output logic signed [VAL_W-1:0]  rsp_mixed_value,
   output logic signed [VAL_W-1:0]  rsp_output_value,
   output logic                     rsp_last,
   // register writes
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]         csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: owns handshakes and channel count
   rcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, store, arithmetic, result payload
   rcm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_source_index (req_source_index),
      .req_source_value (req_source_value),
      .req_device       (req_device),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_channel      (rsp_channel),
      .rsp_mixed_value  (rsp_mixed_value),
      .rsp_output_value (rsp_output_value),
      .rsp_last         (rsp_last)
   );

endmodule
